// ===== rtl/cau_pkg.sv =====
`timescale 1ns / 1ps
package cau_pkg;

  localparam int FRAC_BITS = 8;
  localparam int OpW  = 16;
  localparam int PW   = 2 * OpW + 1;            // signed sum of two products
  localparam int MagW = 2 * OpW;                // magnitude of a divide numerator
  localparam int DW   = 2 * OpW;                // |b|^2
  localparam int QW   = OpW + 1;                // quotient bits kept
  localparam int NW   = MagW + FRAC_BITS + 2;   // scaled numerator plus d
  localparam int RW   = (NW > DW + 1 + QW) ? NW : DW + 1 + QW;

  localparam logic signed [PW-1:0] QMax = (PW'(1) <<< (OpW - 1)) - PW'(1);
  localparam logic signed [PW-1:0] QMin = -QMax - PW'(1);

  typedef enum logic [1:0] {
    CmdAdd = 2'd0,
    CmdSub = 2'd1,
    CmdMul = 2'd2,
    CmdDiv = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                  cmd;
    logic                  dz;
    logic [1:0]            neg;     // [0] real, [1] imag
    logic signed [PW-1:0]  pre_re;  // add/sub/mul result before saturation
    logic signed [PW-1:0]  pre_im;
  } ctx_t;

  typedef struct packed {
    logic signed [OpW-1:0] v;
    logic                  ovf;
  } sat_t;

  function automatic sat_t sat16(input logic signed [PW-1:0] x);
    sat_t s;
    s.ovf = 1'b1;
    if (x > QMax) begin
      s.v = QMax[OpW-1:0];
    end else if (x < QMin) begin
      s.v = QMin[OpW-1:0];
    end else begin
      s.v   = x[OpW-1:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== rtl/cau_front.sv =====
`timescale 1ns / 1ps
module cau_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [1:0]                  command_i,
  input  logic signed [15:0]          a_real_i,
  input  logic signed [15:0]          a_imag_i,
  input  logic signed [15:0]          b_real_i,
  input  logic signed [15:0]          b_imag_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output cau_pkg::ctx_t               ctx_o,
  output logic [cau_pkg::MagW-1:0]    mag_re_o,
  output logic [cau_pkg::MagW-1:0]    mag_im_o,
  output logic [cau_pkg::DW-1:0]      den_o
);
  import cau_pkg::*;

  localparam logic signed [PW-1:0] Half = (PW'(1) <<< FRAC_BITS) >>> 1;

  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  // stage 1: operands
  cmd_e                  cmd1_q;
  logic signed [OpW-1:0] ar_q, ai_q, br_q, bi_q;

  // stage 2: products
  cmd_e                  cmd2_q;
  logic signed [MagW-1:0] prr_q, pii_q, pri_q, pir_q, pbr_q, pbi_q;
  logic signed [PW-1:0]  as_re_q, as_im_q;

  // stage 3: sums
  ctx_t                  ctx_q;
  logic [MagW-1:0]       mre_q, mim_q;
  logic [DW-1:0]         den_q;

  assign en3     = !v3_q || !stall_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cmd1_q <= cmd_e'(command_i);
      ar_q   <= a_real_i;
      ai_q   <= a_imag_i;
      br_q   <= b_real_i;
      bi_q   <= b_imag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      cmd2_q <= cmd1_q;
      prr_q  <= ar_q * br_q;
      pii_q  <= ai_q * bi_q;
      pri_q  <= ar_q * bi_q;
      pir_q  <= ai_q * br_q;
      pbr_q  <= br_q * br_q;
      pbi_q  <= bi_q * bi_q;
      if (cmd1_q == CmdSub) begin
        as_re_q <= PW'(ar_q) - PW'(br_q);
        as_im_q <= PW'(ai_q) - PW'(bi_q);
      end else begin
        as_re_q <= PW'(ar_q) + PW'(br_q);
        as_im_q <= PW'(ai_q) + PW'(bi_q);
      end
    end
  end

  logic signed [PW-1:0] mul_re, mul_im, div_re, div_im;
  logic [DW-1:0]        d;
  ctx_t                 ctx_d;

  always_comb begin
    mul_re = (PW'(prr_q) - PW'(pii_q) + Half) >>> FRAC_BITS;
    mul_im = (PW'(pri_q) + PW'(pir_q) + Half) >>> FRAC_BITS;
    div_re = PW'(prr_q) + PW'(pii_q);
    div_im = PW'(pir_q) - PW'(pri_q);
    d      = DW'(pbr_q) + DW'(pbi_q);
    ctx_d.cmd = cmd2_q;
    ctx_d.dz  = (cmd2_q == CmdDiv) && (d == '0);
    ctx_d.neg = {div_im[PW-1], div_re[PW-1]};
    case (cmd2_q)
      CmdMul: begin
        ctx_d.pre_re = mul_re;
        ctx_d.pre_im = mul_im;
      end
      default: begin
        ctx_d.pre_re = as_re_q;
        ctx_d.pre_im = as_im_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      ctx_q <= ctx_d;
      mre_q <= div_re[PW-1] ? MagW'(-div_re) : MagW'(div_re);
      mim_q <= div_im[PW-1] ? MagW'(-div_im) : MagW'(div_im);
      den_q <= d;
    end
  end

  assign valid_o  = v3_q;
  assign ctx_o    = ctx_q;
  assign mag_re_o = mre_q;
  assign mag_im_o = mim_q;
  assign den_o    = den_q;

endmodule

// ===== rtl/cau_div.sv =====
`timescale 1ns / 1ps
module cau_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  cau_pkg::ctx_t                ctx_i,
  input  logic [cau_pkg::MagW-1:0]     mag_re_i,
  input  logic [cau_pkg::MagW-1:0]     mag_im_i,
  input  logic [cau_pkg::DW-1:0]       den_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output cau_pkg::ctx_t                ctx_o,
  output logic [cau_pkg::QW-1:0]       q_re_o,
  output logic [cau_pkg::QW-1:0]       q_im_o,
  output logic [1:0]                   qovf_o
);
  import cau_pkg::*;

  // stage 0 forms N = |n|*2^(F+1) + d and D = 2d; stage k settles quotient bit QW-k
  logic                v_q   [0:QW];
  ctx_t                ctx_q [0:QW];
  logic [DW:0]         dd_q  [0:QW];
  logic [RW-1:0]       r_q   [0:QW][2];
  logic [QW-1:0]       qt_q  [0:QW][2];
  logic [1:0]          ov_q  [0:QW];
  logic                en    [0:QW+1];

  always_comb begin
    en[QW+1] = !stall_i;
    for (int k = QW; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end
  assign stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QW; k++) v_q[k] <= 1'b0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k <= QW; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ctx_q[0]   <= ctx_i;
      dd_q[0]    <= {den_i, 1'b0};
      r_q[0][0]  <= (RW'(mag_re_i) << (FRAC_BITS + 1)) + RW'(den_i);
      r_q[0][1]  <= (RW'(mag_im_i) << (FRAC_BITS + 1)) + RW'(den_i);
      qt_q[0][0] <= '0;
      qt_q[0][1] <= '0;
      ov_q[0]    <= '0;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [RW-1:0] sh;
    logic [RW-1:0] top;
    logic [RW-1:0] r_d  [2];
    logic [QW-1:0] qt_d [2];
    logic [1:0]    ov_d;

    always_comb begin
      sh  = RW'(dd_q[k-1]) << (QW - k);
      top = RW'(dd_q[k-1]) << QW;
      for (int l = 0; l < 2; l++) begin
        qt_d[l] = qt_q[k-1][l];
        if (r_q[k-1][l] >= sh) begin
          r_d[l]           = r_q[k-1][l] - sh;
          qt_d[l][QW - k]  = 1'b1;
        end else begin
          r_d[l] = r_q[k-1][l];
        end
        // quotient too large for QW bits: checked once, on the first step
        ov_d[l] = (k == 1) ? (r_q[k-1][l] >= top) : ov_q[k-1][l];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        ctx_q[k]   <= ctx_q[k-1];
        dd_q[k]    <= dd_q[k-1];
        r_q[k][0]  <= r_d[0];
        r_q[k][1]  <= r_d[1];
        qt_q[k][0] <= qt_d[0];
        qt_q[k][1] <= qt_d[1];
        ov_q[k]    <= ov_d;
      end
    end
  end

  assign valid_o = v_q[QW];
  assign ctx_o   = ctx_q[QW];
  assign q_re_o  = qt_q[QW][0];
  assign q_im_o  = qt_q[QW][1];
  assign qovf_o  = ov_q[QW];

endmodule

// ===== rtl/complex_arith_unit_top.sv =====
`timescale 1ns / 1ps
// Complex add/sub/mul/div on signed Q8.8 operands, saturating results.
// Pipeline: 3 product/sum stages, 18 divider stages, 1 output register.
// One word per cycle unless stalled; each divider stage settles one quotient bit.
// Pipeline bubbles collapse, so upstream keeps flowing while a result waits.
// Reset (rst_ni, async, active low) clears the valid bits only.
module complex_arith_unit_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic signed [15:0] a_real_i,
  input  logic signed [15:0] a_imag_i,
  input  logic signed [15:0] b_real_i,
  input  logic signed [15:0] b_imag_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] result_real_o,
  output logic signed [15:0] result_imag_o,
  output logic               overflowed_o,
  output logic               divide_by_zero_o
);
  import cau_pkg::*;

  logic            f_valid, f_stall;
  ctx_t            f_ctx;
  logic [MagW-1:0] f_mre, f_mim;
  logic [DW-1:0]   f_den;

  logic            d_valid, d_stall;
  ctx_t            d_ctx;
  logic [QW-1:0]   d_qre, d_qim;
  logic [1:0]      d_qovf;

  cau_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .stall_o   (in_stall_o),
    .command_i (command_i),
    .a_real_i  (a_real_i),
    .a_imag_i  (a_imag_i),
    .b_real_i  (b_real_i),
    .b_imag_i  (b_imag_i),
    .valid_o   (f_valid),
    .stall_i   (f_stall),
    .ctx_o     (f_ctx),
    .mag_re_o  (f_mre),
    .mag_im_o  (f_mim),
    .den_o     (f_den)
  );

  cau_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (f_valid),
    .stall_o  (f_stall),
    .ctx_i    (f_ctx),
    .mag_re_i (f_mre),
    .mag_im_i (f_mim),
    .den_i    (f_den),
    .valid_o  (d_valid),
    .stall_i  (d_stall),
    .ctx_o    (d_ctx),
    .q_re_o   (d_qre),
    .q_im_o   (d_qim),
    .qovf_o   (d_qovf)
  );

  localparam logic signed [PW-1:0] Big = PW'(1) <<< QW;

  function automatic logic signed [PW-1:0] signed_q(input logic [QW-1:0] q,
                                                    input logic neg, input logic ovf);
    logic signed [PW-1:0] m;
    m = ovf ? Big : PW'(q);
    return neg ? -m : m;
  endfunction

  logic   en;
  logic   vo_q;
  sat_t   s_re, s_im;
  logic [OpW-1:0] re_q, im_q;
  logic   ovf_q, dz_q;

  always_comb begin
    if (d_ctx.cmd == CmdDiv) begin
      s_re = sat16(signed_q(d_qre, d_ctx.neg[0], d_qovf[0]));
      s_im = sat16(signed_q(d_qim, d_ctx.neg[1], d_qovf[1]));
      if (d_ctx.dz) begin
        s_re = '0;
        s_im = '0;
      end
    end else begin
      s_re = sat16(d_ctx.pre_re);
      s_im = sat16(d_ctx.pre_im);
    end
  end

  assign en      = !vo_q || !out_stall_i;
  assign d_stall = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      re_q  <= s_re.v;
      im_q  <= s_im.v;
      ovf_q <= s_re.ovf || s_im.ovf;
      dz_q  <= d_ctx.dz;
    end
  end

  assign out_valid_o      = vo_q;
  assign result_real_o    = re_q;
  assign result_imag_o    = im_q;
  assign overflowed_o     = ovf_q;
  assign divide_by_zero_o = dz_q;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import cau_pkg::*;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [15:0] ar;
    logic signed [15:0] ai;
    logic signed [15:0] br;
    logic signed [15:0] bi;
  } op_word_t;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               ovf;
    logic               dz;
  } res_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] command_i = '0;
  logic signed [15:0] a_real_i = '0, a_imag_i = '0, b_real_i = '0, b_imag_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] result_real_o, result_imag_o;
  logic overflowed_o, divide_by_zero_o;

  complex_arith_unit_top dut (.*);

  always #1 clk_i = ~clk_i;

  op_word_t  pending_ops[$];
  res_word_t expected_res[$];
  int        err_count = 0;
  int        send_idle_pct = 19;
  int        recv_idle_pct = 66;
  int        hold_cycles = 0;

  function automatic longint sat_part(input longint v, inout bit ovf);
    if (v > 32767) begin
      ovf = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      ovf = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  // round(n * 2^FRAC_BITS / d), ties away from zero
  function automatic longint quot_round(input longint n, input longint d);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (mag * (longint'(1) << FRAC_BITS) * 2 + d) / (2 * d);
    if (q > (longint'(1) << 40)) q = longint'(1) << 40;
    return (n < 0) ? -q : q;
  endfunction

  // floor of (v + half) >> FRAC_BITS; >>> on longint is arithmetic
  function automatic longint prod_round(input longint v);
    return (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic res_word_t complex_result(input op_word_t w);
    res_word_t r;
    longint ar, ai, br, bi, re, im, d;
    bit ovf;
    ar = w.ar; ai = w.ai; br = w.br; bi = w.bi;
    re = 0; im = 0; ovf = 1'b0;
    r.dz = 1'b0;
    case (w.cmd)
      CmdAdd: begin re = ar + br; im = ai + bi; end
      CmdSub: begin re = ar - br; im = ai - bi; end
      CmdMul: begin
        re = prod_round(ar * br - ai * bi);
        im = prod_round(ar * bi + ai * br);
      end
      default: begin
        d = br * br + bi * bi;
        if (d == 0) begin
          r.dz = 1'b1;
        end else begin
          re = quot_round(ar * br + ai * bi, d);
          im = quot_round(ai * br - ar * bi, d);
        end
      end
    endcase
    re = sat_part(re, ovf);
    im = sat_part(im, ovf);
    r.re = re[15:0];
    r.im = im[15:0];
    r.ovf = ovf;
    return r;
  endfunction

  function automatic logic [15:0] rnd_part();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 1023)) - 512);
      3: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_op(input cmd_e c, input logic [15:0] ar, ai, br, bi);
    op_word_t w;
    w.cmd = c; w.ar = ar; w.ai = ai; w.br = br; w.bi = bi;
    pending_ops.push_back(w);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          op_word_t w;
          w = pending_ops.pop_front();
          expected_res.push_back(complex_result(w));
          in_valid_i <= 1'b1;
          command_i <= w.cmd;
          a_real_i <= w.ar; a_imag_i <= w.ai;
          b_real_i <= w.br; b_imag_i <= w.bi;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_res.size() == 0) begin
        $error("unexpected word: re=%0d im=%0d", result_real_o, result_imag_o);
        err_count++;
      end else begin
        res_word_t e;
        e = expected_res.pop_front();
        if (result_real_o !== e.re) begin
          $error("result_real exp %0d got %0d", e.re, result_real_o); err_count++;
        end
        if (result_imag_o !== e.im) begin
          $error("result_imag exp %0d got %0d", e.im, result_imag_o); err_count++;
        end
        if (overflowed_o !== e.ovf) begin
          $error("overflowed exp %0b got %0b", e.ovf, overflowed_o); err_count++;
        end
        if (divide_by_zero_o !== e.dz) begin
          $error("divide_by_zero exp %0b got %0b", e.dz, divide_by_zero_o); err_count++;
        end
      end
    end
  end

  initial begin
    cmd_e c;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, every op, zero divisor, saturation
    for (int k = 0; k < 4; k++) begin
      c = cmd_e'(k);
      push_op(c, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      push_op(c, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      push_op(c, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
      push_op(c, 16'sh0100, 16'sh0080, 16'shff00, 16'sh0040);
      push_op(c, 16'sh1234, 16'shedcc, 16'sh0000, 16'sh0000);
    end
    push_op(CmdDiv, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    push_op(CmdDiv, 16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0001);
    push_op(CmdMul, 16'sh0001, 16'sh0000, 16'sh0080, 16'sh0000);
    push_op(CmdMul, 16'shffff, 16'sh0000, 16'sh0080, 16'sh0000);
    push_op(CmdDiv, 16'sh0001, 16'sh0000, 16'sh0200, 16'sh0000);
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 66; recv_idle_pct = 19;
      end else if (phase == 2) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int n = 0; n < 630; n++) begin
        c = cmd_e'($urandom_range(0, 3));
        if (c == CmdDiv && $urandom_range(0, 9) == 0)
          push_op(c, rnd_part(), rnd_part(), 16'sh0000, 16'sh0000);
        else
          push_op(c, rnd_part(), rnd_part(), rnd_part(), rnd_part());
      end
      if (phase == 0) begin
        @(posedge clk_i);
        hold_cycles = 200;
      end
      wait (pending_ops.size() == 0);
    end
    wait (expected_res.size() == 0);
    repeat (40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div.sv
rtl/complex_arith_unit_top.sv
sim/tb_top.sv
